// ===== rtl/core/ts_psi_table_parser_macros.svh =====
// Assertion macros shared by the transport stream PSI parser.
`ifndef TS_PSI_TABLE_PARSER_MACROS_SVH
`define TS_PSI_TABLE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSPSI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSPSI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tspsi_pkg.sv =====
`timescale 1ns / 1ps

package tspsi_pkg;

    // Packet framing.
    localparam logic [7:0] PACKET_BYTES = 8'd188;
    localparam logic [7:0] SYNC_BYTE    = 8'h47;

    // Parser phases.
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_POINTER  = 4'd1;
    localparam logic [3:0] PH_SKIP_PTR = 4'd2;
    localparam logic [3:0] PH_TABLE_ID = 4'd3;
    localparam logic [3:0] PH_LEN_HI   = 4'd4;
    localparam logic [3:0] PH_LEN_LO   = 4'd5;
    localparam logic [3:0] PH_PAT_HDR  = 4'd6;
    localparam logic [3:0] PH_PAT_REC  = 4'd7;
    localparam logic [3:0] PH_PMT_HDR  = 4'd8;
    localparam logic [3:0] PH_PMT_INFO = 4'd9;
    localparam logic [3:0] PH_STREAM   = 4'd10;
    localparam logic [3:0] PH_ES_SKIP  = 4'd11;

    // Result kinds.
    localparam logic [1:0] KIND_SYNC_ERR  = 2'd0;
    localparam logic [1:0] KIND_PROGRAM   = 2'd1;
    localparam logic [1:0] KIND_MAP_HDR   = 2'd2;
    localparam logic [1:0] KIND_STREAM    = 2'd3;

    // Stream classes.
    localparam logic [1:0] CLASS_OTHER = 2'd0;
    localparam logic [1:0] CLASS_VIDEO = 2'd1;
    localparam logic [1:0] CLASS_AUDIO = 2'd2;
    localparam logic [7:0] TYPE_VIDEO  = 8'h02;
    localparam logic [7:0] TYPE_AUDIO  = 8'h04;

    // Section layout.
    localparam logic [11:0] CRC_BYTES       = 12'd4;
    localparam logic [11:0] COUNT_MAX       = 12'hFFF;
    localparam logic [11:0] PAT_HDR_BYTES   = 12'd5;
    localparam logic [11:0] PMT_IDX_NUM_HI  = 12'd0;
    localparam logic [11:0] PMT_IDX_NUM_LO  = 12'd1;
    localparam logic [11:0] PMT_IDX_INFO_HI = 12'd7;
    localparam logic [11:0] PMT_IDX_INFO_LO = 12'd8;
    localparam logic [11:0] ES_IDX_TYPE     = 12'd0;
    localparam logic [11:0] ES_IDX_PID_HI   = 12'd1;
    localparam logic [11:0] ES_IDX_PID_LO   = 12'd2;
    localparam logic [11:0] ES_IDX_LEN_HI   = 12'd3;
    localparam logic [11:0] PAT_REC_LAST    = 12'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } tspsi_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  section_tid;
        logic [15:0] number;
        logic [12:0] entry_pid;
        logic [1:0]  stream_class;
    } tspsi_result_t;

endpackage

// ===== rtl/core/tspsi_in_reg.sv =====
`timescale 1ns / 1ps

module tspsi_in_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tspsi_pkg::tspsi_item_t in_item,
    output logic                  item_valid,
    input  logic                  item_take,
    output tspsi_pkg::tspsi_item_t item
);

    logic                   valid_reg;
    logic                   valid_next;
    tspsi_pkg::tspsi_item_t item_reg;

    // The register takes a new transaction when empty or when its item moves on.
    assign in_ready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/tspsi_parser.sv =====
`timescale 1ns / 1ps
`include "ts_psi_table_parser_macros.svh"

module tspsi_parser (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  tspsi_pkg::tspsi_item_t  item,
    output logic                    res_valid,
    output tspsi_pkg::tspsi_result_t res
);

    logic [7:0]  pos_reg,        pos_next;
    logic [12:0] pid_reg,        pid_next;
    logic        start_flag_reg, start_flag_next;
    logic        dropped_reg,    dropped_next;
    logic [3:0]  phase_reg,      phase_next;
    logic [11:0] skip_reg,       skip_next;
    logic [11:0] sec_len_reg,    sec_len_next;
    logic [11:0] sec_cnt_reg,    sec_cnt_next;
    logic [23:0] shift_reg,      shift_next;
    logic [7:0]  table_reg,      table_next;
    logic [12:0] map_pid_reg,    map_pid_next;

    logic [7:0]  d;
    logic [11:0] lim;
    logic [11:0] skip_dec;
    logic [11:0] len;
    logic [7:0]  es_type;
    logic        stop;

    assign d        = item.data_byte;
    assign lim      = (sec_len_reg >= tspsi_pkg::CRC_BYTES) ?
                      (sec_len_reg - tspsi_pkg::CRC_BYTES) : 12'd0;
    assign skip_dec = (skip_reg != 12'd0) ? (skip_reg - 12'd1) : 12'd0;
    assign len      = {shift_reg[3:0], d};
    assign es_type  = shift_reg[15:8];

    // Byte-wise packet and section parser: next state and result of one byte.
    always_comb begin
        pos_next        = pos_reg;
        pid_next        = pid_reg;
        start_flag_next = start_flag_reg;
        dropped_next    = dropped_reg;
        phase_next      = phase_reg;
        skip_next       = skip_reg;
        sec_len_next    = sec_len_reg;
        sec_cnt_next    = sec_cnt_reg;
        shift_next      = shift_reg;
        table_next      = table_reg;
        map_pid_next    = map_pid_reg;
        res_valid       = 1'b0;
        res             = '0;
        stop            = 1'b0;

        if (step) begin
            if (item.packet_start) begin
                pos_next   = 8'd1;
                phase_next = tspsi_pkg::PH_IDLE;
                if (d != tspsi_pkg::SYNC_BYTE) begin
                    dropped_next = 1'b1;
                    res_valid    = 1'b1;
                    res.kind     = tspsi_pkg::KIND_SYNC_ERR;
                end else begin
                    dropped_next = 1'b0;
                end
            end else if (pos_reg != 8'd0 && pos_reg < tspsi_pkg::PACKET_BYTES
                         && !dropped_reg) begin
                pos_next = pos_reg + 8'd1;
                if (pos_reg == 8'd1) begin
                    start_flag_next = d[6];
                    pid_next        = {d[4:0], 8'd0};
                end else if (pos_reg == 8'd2) begin
                    pid_next = {pid_reg[12:8], d};
                end else if (pos_reg == 8'd3) begin
                    if (start_flag_reg && (pid_reg == 13'd0 || pid_reg == map_pid_reg)) begin
                        phase_next = tspsi_pkg::PH_POINTER;
                    end else begin
                        phase_next = tspsi_pkg::PH_IDLE;
                    end
                end else begin
                    // Section byte accounting and the stop before the CRC.
                    if (phase_reg >= tspsi_pkg::PH_PAT_HDR) begin
                        if ((phase_reg == tspsi_pkg::PH_PAT_REC ||
                             phase_reg == tspsi_pkg::PH_STREAM) &&
                            skip_reg == 12'd0 && sec_cnt_reg >= lim) begin
                            phase_next = tspsi_pkg::PH_IDLE;
                            stop       = 1'b1;
                        end else if (sec_cnt_reg != tspsi_pkg::COUNT_MAX) begin
                            sec_cnt_next = sec_cnt_reg + 12'd1;
                        end
                    end

                    if (!stop) begin
                        unique case (phase_reg)
                            tspsi_pkg::PH_POINTER: begin
                                skip_next  = {4'd0, d};
                                phase_next = (d != 8'd0) ? tspsi_pkg::PH_SKIP_PTR :
                                                           tspsi_pkg::PH_TABLE_ID;
                            end
                            tspsi_pkg::PH_SKIP_PTR: begin
                                skip_next = skip_dec;
                                if (skip_dec == 12'd0) begin
                                    phase_next = tspsi_pkg::PH_TABLE_ID;
                                end
                            end
                            tspsi_pkg::PH_TABLE_ID: begin
                                table_next = d;
                                phase_next = tspsi_pkg::PH_LEN_HI;
                            end
                            tspsi_pkg::PH_LEN_HI: begin
                                shift_next = {16'd0, d};
                                phase_next = tspsi_pkg::PH_LEN_LO;
                            end
                            tspsi_pkg::PH_LEN_LO: begin
                                sec_len_next = len;
                                sec_cnt_next = 12'd0;
                                if (pid_reg == 13'd0) begin
                                    skip_next  = tspsi_pkg::PAT_HDR_BYTES;
                                    phase_next = tspsi_pkg::PH_PAT_HDR;
                                end else begin
                                    skip_next  = 12'd0;
                                    phase_next = tspsi_pkg::PH_PMT_HDR;
                                end
                            end
                            tspsi_pkg::PH_PAT_HDR, tspsi_pkg::PH_PMT_INFO,
                            tspsi_pkg::PH_ES_SKIP: begin
                                skip_next = skip_dec;
                                if (skip_dec == 12'd0) begin
                                    phase_next = (phase_reg == tspsi_pkg::PH_PAT_HDR) ?
                                                 tspsi_pkg::PH_PAT_REC :
                                                 tspsi_pkg::PH_STREAM;
                                end
                            end
                            tspsi_pkg::PH_PAT_REC: begin
                                if (skip_reg < tspsi_pkg::PAT_REC_LAST) begin
                                    shift_next = {shift_reg[15:0], d};
                                    skip_next  = skip_reg + 12'd1;
                                end else begin
                                    skip_next        = 12'd0;
                                    map_pid_next     = {shift_reg[4:0], d};
                                    res_valid        = 1'b1;
                                    res.kind         = tspsi_pkg::KIND_PROGRAM;
                                    res.section_tid  = table_reg;
                                    res.number       = shift_reg[23:8];
                                    res.entry_pid    = {shift_reg[4:0], d};
                                end
                            end
                            tspsi_pkg::PH_PMT_HDR: begin
                                skip_next = skip_reg + 12'd1;
                                if (skip_reg == tspsi_pkg::PMT_IDX_NUM_HI ||
                                    skip_reg == tspsi_pkg::PMT_IDX_INFO_HI) begin
                                    shift_next = {16'd0, d};
                                end else if (skip_reg == tspsi_pkg::PMT_IDX_NUM_LO) begin
                                    res_valid       = 1'b1;
                                    res.kind        = tspsi_pkg::KIND_MAP_HDR;
                                    res.section_tid = table_reg;
                                    res.number      = {shift_reg[7:0], d};
                                end else if (skip_reg >= tspsi_pkg::PMT_IDX_INFO_LO) begin
                                    skip_next  = len;
                                    phase_next = (len != 12'd0) ? tspsi_pkg::PH_PMT_INFO :
                                                                  tspsi_pkg::PH_STREAM;
                                end
                            end
                            tspsi_pkg::PH_STREAM: begin
                                skip_next = skip_reg + 12'd1;
                                if (skip_reg == tspsi_pkg::ES_IDX_TYPE ||
                                    skip_reg == tspsi_pkg::ES_IDX_LEN_HI) begin
                                    shift_next = {16'd0, d};
                                end else if (skip_reg == tspsi_pkg::ES_IDX_PID_HI) begin
                                    shift_next = {8'd0, shift_reg[7:0], d};
                                end else if (skip_reg == tspsi_pkg::ES_IDX_PID_LO) begin
                                    res_valid       = 1'b1;
                                    res.kind        = tspsi_pkg::KIND_STREAM;
                                    res.section_tid = table_reg;
                                    res.number      = {8'd0, es_type};
                                    res.entry_pid   = {shift_reg[4:0], d};
                                    if (es_type == tspsi_pkg::TYPE_VIDEO) begin
                                        res.stream_class = tspsi_pkg::CLASS_VIDEO;
                                    end else if (es_type == tspsi_pkg::TYPE_AUDIO) begin
                                        res.stream_class = tspsi_pkg::CLASS_AUDIO;
                                    end else begin
                                        res.stream_class = tspsi_pkg::CLASS_OTHER;
                                    end
                                end else begin
                                    skip_next  = len;
                                    phase_next = (len != 12'd0) ? tspsi_pkg::PH_ES_SKIP :
                                                                  tspsi_pkg::PH_STREAM;
                                end
                            end
                            default: begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= 8'd0;
            pid_reg        <= 13'd0;
            start_flag_reg <= 1'b0;
            dropped_reg    <= 1'b0;
            phase_reg      <= tspsi_pkg::PH_IDLE;
            skip_reg       <= 12'd0;
            sec_len_reg    <= 12'd0;
            sec_cnt_reg    <= 12'd0;
            shift_reg      <= 24'd0;
            table_reg      <= 8'd0;
            map_pid_reg    <= 13'd0;
        end else begin
            pos_reg        <= pos_next;
            pid_reg        <= pid_next;
            start_flag_reg <= start_flag_next;
            dropped_reg    <= dropped_next;
            phase_reg      <= phase_next;
            skip_reg       <= skip_next;
            sec_len_reg    <= sec_len_next;
            sec_cnt_reg    <= sec_cnt_next;
            shift_reg      <= shift_next;
            table_reg      <= table_next;
            map_pid_reg    <= map_pid_next;
        end
    end

    // The byte position never runs past the end of a packet.
    `TSPSI_ASSERT_NOW(a_pos_in_packet, aclk, aresetn, 1'b1,
        pos_reg <= tspsi_pkg::PACKET_BYTES, "byte position beyond packet end")

    // A packet start reopens the packet and abandons any section.
    `TSPSI_ASSERT_NEXT(a_start_reopens, aclk, aresetn, step && item.packet_start,
        pos_reg == 8'd1 && phase_reg == tspsi_pkg::PH_IDLE,
        "packet start did not reset the parser")

    // Sync errors come only from a packet's first byte.
    `TSPSI_ASSERT_NOW(a_sync_on_start, aclk, aresetn,
        res_valid && res.kind == tspsi_pkg::KIND_SYNC_ERR,
        step && item.packet_start, "sync error outside a packet start")

    // Stream entries come only while reading the stream loop.
    `TSPSI_ASSERT_NOW(a_stream_phase, aclk, aresetn,
        res_valid && res.kind == tspsi_pkg::KIND_STREAM,
        phase_reg == tspsi_pkg::PH_STREAM, "stream entry outside stream loop")

endmodule

// ===== rtl/core/tspsi_out_reg.sv =====
`timescale 1ns / 1ps

module tspsi_out_reg (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step,
    input  logic                     res_valid,
    input  tspsi_pkg::tspsi_result_t res,
    output logic                     can_take,
    output logic                     out_valid,
    input  logic                     out_ready,
    output tspsi_pkg::tspsi_result_t out_res
);

    logic                     valid_reg;
    logic                     valid_next;
    tspsi_pkg::tspsi_result_t res_reg;

    // Room for a result when empty or when the waiting one leaves this cycle.
    assign can_take = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (step) begin
            valid_next = res_valid;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/core/ts_psi_table_parser.sv =====
// Transport stream PSI table parser (program association and program map).
// Input channel s_*: one stream byte per transaction in s_tdata, with s_tuser
// high on the first byte of each 188-byte packet. Result channel m_*: sync
// errors, program entries, map table headers and stream entries, kind in
// m_tuser and the remaining fields packed in m_tdata.
// Throughput is one byte per cycle while the output register has room; most
// bytes give no result. A byte accepted into the input register is parsed by
// the byte-wise state machine once the output register has room, and its
// result is registered in the output register and presented on m_tvalid.
// Reset (aresetn low, synchronous) empties both registers, closes any open
// packet and forgets the map PID; bytes before the next packet start are
// dropped.
// When the receiver holds m_tready low, the result waits in the output
// register and one more byte is still taken into the input register; after
// that s_tready falls until the result is taken.
`timescale 1ns / 1ps
`include "ts_psi_table_parser_macros.svh"

module ts_psi_table_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] packet_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] section_tid, [23:8] number,
                                   // [36:24] entry_pid, [38:37] stream_class
    output logic [1:0]  m_tuser    // [1:0] kind
);

    tspsi_pkg::tspsi_item_t   in_item;
    tspsi_pkg::tspsi_item_t   item;
    tspsi_pkg::tspsi_result_t res;
    tspsi_pkg::tspsi_result_t out_res;
    logic                     item_valid;
    logic                     can_take;
    logic                     step;
    logic                     res_valid;

    assign in_item.data_byte    = s_tdata;
    assign in_item.packet_start = s_tuser;

    // A byte is parsed when it is held and the output has room.
    assign step = item_valid && can_take;

    tspsi_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (step),
        .item       (item)
    );

    tspsi_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    tspsi_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .can_take  (can_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {1'b0, out_res.stream_class, out_res.entry_pid,
                      out_res.number, out_res.section_tid};

    // A stalled result must not be overwritten by a parsed byte.
    `TSPSI_ASSERT_NOW(a_no_overwrite, aclk, aresetn, m_tvalid && !m_tready,
        !step, "parsed a byte while the result was stalled")

    // The pad bit of the result data stays clear.
    `TSPSI_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid,
        m_tdata[39] == 1'b0, "result pad bit set")

endmodule
